// File: design/mcmf_pkg.sv
`timescale 1ns / 1ps
// Shared constants of the min-cost max-flow engine: opcodes, status codes,
// configuration register indexes and the "infinite" capacity. No dependencies.
package mcmf_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] CFG_SOURCE = 2'd0;
  localparam logic [1:0] CFG_SINK   = 2'd1;
  localparam logic [1:0] CFG_ES_EN  = 2'd2;
  localparam logic [1:0] CFG_LIMIT  = 2'd3;

  localparam logic [31:0] FLOW_INF = 32'h3f3f_3f3f;
  localparam logic [47:0] COST_MAX = 48'hffff_ffff_ffff;

endpackage

// File: design/min_cost_max_flow_engine_unit.sv
`timescale 1ns / 1ps
// Top level of the min-cost max-flow engine: sequencer, edge and node stores.
// Depends on mcmf_pkg and mcmf_ram.
//
// Commands are taken when start is high and busy is low; each command gives one
// result on done_o for a single cycle, which the receiver must take as it comes.
// After reset the block sweeps the adjacency heads before it first drops busy;
// a clear command takes the same sweep and gives its result in the cycle after
// it. An add-edge command writes the forward edge, then the reverse edge, then
// gives its result and drops busy. A run first clears the flow of every stored
// edge, then each shortest-path search resets the node store, dequeues nodes
// and scans their edges, and each augmenting path is walked back from the sink
// twice, once to find its bottleneck and once to apply it; the single read port
// of each node and edge memory sets the pace of these steps.
module min_cost_max_flow_engine_unit
  import mcmf_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [9:0]  from_node_i,
  input  logic [9:0]  to_node_i,
  input  logic [29:0] capacity_i,
  input  logic [15:0] unit_cost_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] total_flow_o,
  output logic [47:0] total_cost_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int ECW = EW + 1;
  localparam int TW  = NW + 1;
  localparam int CW  = (ECW > TW) ? ECW : TW;

  localparam logic [ECW-1:0] NO_EDGE = '1;

  typedef struct packed {
    logic [NW-1:0]      target;
    logic [ECW-1:0]     link;
    logic [29:0]        cap;
    logic signed [16:0] weight;
  } edge_t;

  typedef struct packed {
    logic signed [31:0] path_cost;
    logic [ECW-1:0]     pred;
    logic               queued;
    logic [TW-1:0]      tally;
  } node_t;

  typedef enum logic [20:0] {
    S_CLR    = 21'h000001,
    S_IDLE   = 21'h000002,
    S_ADD_WA = 21'h000004,
    S_ADD_WB = 21'h000008,
    S_FCLR   = 21'h000010,
    S_INIT   = 21'h000020,
    S_POP    = 21'h000040,
    S_POPW   = 21'h000080,
    S_U      = 21'h000100,
    S_EDGE   = 21'h000200,
    S_EV     = 21'h000400,
    S_RELAX  = 21'h000800,
    S_CHKW   = 21'h001000,
    S_WA     = 21'h002000,
    S_WB     = 21'h004000,
    S_WC     = 21'h008000,
    S_WD     = 21'h010000,
    S_MUL    = 21'h020000,
    S_ACC    = 21'h040000,
    S_RESP   = 21'h080000,
    S_SPARE  = 21'h100000
  } state_e;

  // Control registers.
  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            rpt_q, rpt_d;
  logic [ECW-1:0]  edge_cnt_q, edge_cnt_d;
  logic [9:0]      src_q, src_d;
  logic [9:0]      snk_q, snk_d;
  logic            es_en_q, es_en_d;
  logic [31:0]     limit_q, limit_d;
  logic [NW-1:0]   rd_q, rd_d;
  logic [NW-1:0]   wr_q, wr_d;
  logic [TW-1:0]   fill_q, fill_d;
  logic [TW-1:0]   steps_q, steps_d;
  logic            aug_q, aug_d;

  // Payload registers.
  logic [NW-1:0]       a_q, a_d;
  logic [NW-1:0]       b_q, b_d;
  logic [29:0]         cap_q, cap_d;
  logic [15:0]         w_q, w_d;
  logic [NW-1:0]       u_q, u_d;
  logic signed [31:0]  du_q, du_d;
  logic [ECW-1:0]      e_q, e_d;
  logic [NW-1:0]       v_q, v_d;
  logic [ECW-1:0]      link_q, link_d;
  logic signed [31:0]  nd_q, nd_d;
  logic                ok_q, ok_d;
  logic signed [31:0]  dsink_q, dsink_d;
  logic [ECW-1:0]      psink_q, psink_d;
  logic [29:0]         low_q, low_d;
  logic signed [63:0]  prod_q, prod_d;
  logic [1:0]          status_q, status_d;
  logic [31:0]         flow_q, flow_d;
  logic [47:0]         cost_q, cost_d;

  // Memory ports.
  logic           fe_we;
  logic [NW-1:0]  fe_waddr, fe_raddr;
  logic [ECW-1:0] fe_wdata, fe_rdata;
  logic           ed_we;
  logic [EW-1:0]  ed_waddr, ed_raddr;
  edge_t          ed_wdata, ed_rdata;
  logic           fl_we;
  logic [EW-1:0]  fl_waddr, fl_raddr;
  logic [30:0]    fl_wdata, fl_rdata;
  logic           nd_we;
  logic [NW-1:0]  nd_waddr, nd_raddr;
  node_t          nd_wdata, nd_rdata;
  logic           wq_we;
  logic [NW-1:0]  wq_waddr, wq_raddr;
  logic [NW-1:0]  wq_wdata, wq_rdata;

  logic               accept;
  logic [EW-1:0]      e_pair;
  logic signed [31:0] resid;
  logic signed [63:0] cost_sum;
  logic [32:0]        flow_sum;
  logic [NW-1:0]      src_idx, snk_idx;

  mcmf_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES)) u_first_ram (
    .clk_i, .we_i(fe_we), .waddr_i(fe_waddr), .wdata_i(fe_wdata),
    .raddr_i(fe_raddr), .rdata_o(fe_rdata)
  );

  mcmf_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(ed_we), .waddr_i(ed_waddr), .wdata_i(ed_wdata),
    .raddr_i(ed_raddr), .rdata_o(ed_rdata)
  );

  mcmf_ram #(.WIDTH(31), .DEPTH(MAX_EDGES)) u_flow_ram (
    .clk_i, .we_i(fl_we), .waddr_i(fl_waddr), .wdata_i(fl_wdata),
    .raddr_i(fl_raddr), .rdata_o(fl_rdata)
  );

  mcmf_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i, .we_i(nd_we), .waddr_i(nd_waddr), .wdata_i(nd_wdata),
    .raddr_i(nd_raddr), .rdata_o(nd_rdata)
  );

  mcmf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk_i, .we_i(wq_we), .waddr_i(wq_waddr), .wdata_i(wq_wdata),
    .raddr_i(wq_raddr), .rdata_o(wq_rdata)
  );

  assign busy         = (state_q != S_IDLE);
  assign accept       = start && !busy;
  assign cfg_ready_o  = 1'b1;
  assign done_o       = (state_q == S_RESP);
  assign status_o     = status_q;
  assign total_flow_o = flow_q;
  assign total_cost_o = cost_q;

  assign src_idx  = NW'(src_q);
  assign snk_idx  = NW'(snk_q);
  assign e_pair   = {e_q[EW-1:1], ~e_q[0]};
  assign resid    = $signed({2'b00, ed_rdata.cap}) - $signed({fl_rdata[30], fl_rdata});
  assign cost_sum = $signed({16'd0, cost_q}) + prod_q;
  assign flow_sum = {1'b0, flow_q} + {3'd0, low_q};

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rpt_d      = rpt_q;
    edge_cnt_d = edge_cnt_q;
    src_d      = src_q;
    snk_d      = snk_q;
    es_en_d    = es_en_q;
    limit_d    = limit_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    fill_d     = fill_q;
    steps_d    = steps_q;
    aug_d      = aug_q;
    a_d        = a_q;
    b_d        = b_q;
    cap_d      = cap_q;
    w_d        = w_q;
    u_d        = u_q;
    du_d       = du_q;
    e_d        = e_q;
    v_d        = v_q;
    link_d     = link_q;
    nd_d       = nd_q;
    ok_d       = ok_q;
    dsink_d    = dsink_q;
    psink_d    = psink_q;
    low_d      = low_q;
    prod_d     = prod_q;
    status_d   = status_q;
    flow_d     = flow_q;
    cost_d     = cost_q;

    fe_we    = 1'b0;
    fe_waddr = cnt_q[NW-1:0];
    fe_wdata = NO_EDGE;
    fe_raddr = a_q;
    ed_we    = 1'b0;
    ed_waddr = edge_cnt_q[EW-1:0];
    ed_wdata = '0;
    ed_raddr = e_q[EW-1:0];
    fl_we    = 1'b0;
    fl_waddr = edge_cnt_q[EW-1:0];
    fl_wdata = '0;
    fl_raddr = e_q[EW-1:0];
    nd_we    = 1'b0;
    nd_waddr = cnt_q[NW-1:0];
    nd_wdata = '0;
    nd_raddr = v_q;
    wq_we    = 1'b0;
    wq_waddr = wr_q;
    wq_wdata = v_q;
    wq_raddr = rd_q;

    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SOURCE: src_d   = cfg_data_i[9:0];
        CFG_SINK:   snk_d   = cfg_data_i[9:0];
        CFG_ES_EN:  es_en_d = cfg_data_i[0];
        CFG_LIMIT:  limit_d = cfg_data_i;
      endcase
    end

    unique case (state_q)
      S_CLR: begin
        fe_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(MAX_NODES - 1)) begin
          state_d = rpt_q ? S_RESP : S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          flow_d   = '0;
          cost_d   = '0;
          a_d      = NW'(from_node_i);
          b_d      = NW'(to_node_i);
          cap_d    = capacity_i;
          w_d      = unit_cost_i;
          cnt_d    = '0;
          state_d  = S_RESP;
          case (opcode_i)
            OP_CLEAR: begin
              rpt_d      = 1'b1;
              edge_cnt_d = '0;
              state_d    = S_CLR;
            end
            OP_ADD: begin
              fe_raddr = NW'(from_node_i);
              if ({22'd0, from_node_i} >= MAX_NODES || {22'd0, to_node_i} >= MAX_NODES) begin
                status_d = ST_RANGE;
              end else if (32'(edge_cnt_q) + 32'd2 > MAX_EDGES) begin
                status_d = ST_FULL;
              end else begin
                state_d = S_ADD_WA;
              end
            end
            OP_RUN: begin
              if ({22'd0, src_q} >= MAX_NODES || {22'd0, snk_q} >= MAX_NODES) begin
                status_d = ST_RANGE;
              end else begin
                state_d = S_FCLR;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      S_ADD_WA: begin
        ed_we    = 1'b1;
        ed_wdata = '{target: b_q, link: fe_rdata, cap: cap_q,
                     weight: $signed({1'b0, w_q})};
        fl_we    = 1'b1;
        fe_we    = 1'b1;
        fe_waddr = a_q;
        fe_wdata = edge_cnt_q;
        fe_raddr = b_q;
        state_d  = S_ADD_WB;
      end

      S_ADD_WB: begin
        ed_we      = 1'b1;
        ed_waddr   = EW'(edge_cnt_q + 1'b1);
        ed_wdata   = '{target: a_q, link: (a_q == b_q) ? edge_cnt_q : fe_rdata,
                       cap: '0, weight: -$signed({1'b0, w_q})};
        fl_we      = 1'b1;
        fl_waddr   = EW'(edge_cnt_q + 1'b1);
        fe_we      = 1'b1;
        fe_waddr   = b_q;
        fe_wdata   = edge_cnt_q + 1'b1;
        edge_cnt_d = edge_cnt_q + ECW'(2);
        state_d    = S_RESP;
      end

      S_FCLR: begin
        if (cnt_q == CW'(edge_cnt_q)) begin
          cnt_d   = '0;
          state_d = S_INIT;
        end else begin
          fl_we    = 1'b1;
          fl_waddr = cnt_q[EW-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
      end

      S_INIT: begin
        nd_we = 1'b1;
        if (cnt_q[NW-1:0] == src_idx) begin
          nd_wdata = '{path_cost: '0, pred: NO_EDGE, queued: 1'b1, tally: TW'(1)};
        end else begin
          nd_wdata = '{path_cost: $signed(FLOW_INF), pred: NO_EDGE, queued: 1'b0,
                       tally: '0};
        end
        if (cnt_q == '0) begin
          wq_we    = 1'b1;
          wq_waddr = '0;
          wq_wdata = src_idx;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(MAX_NODES - 1)) begin
          rd_d    = '0;
          wr_d    = NW'(1);
          fill_d  = TW'(1);
          state_d = S_POP;
        end
      end

      S_POP: begin
        if (fill_q == '0) begin
          nd_raddr = snk_idx;
          state_d  = S_CHKW;
        end else begin
          wq_raddr = rd_q;
          rd_d     = (rd_q == NW'(MAX_NODES - 1)) ? '0 : rd_q + 1'b1;
          fill_d   = fill_q - 1'b1;
          state_d  = S_POPW;
        end
      end

      S_POPW: begin
        u_d      = wq_rdata;
        nd_raddr = wq_rdata;
        fe_raddr = wq_rdata;
        state_d  = S_U;
      end

      S_U: begin
        du_d            = nd_rdata.path_cost;
        nd_we           = 1'b1;
        nd_waddr        = u_q;
        nd_wdata        = nd_rdata;
        nd_wdata.queued = 1'b0;
        e_d             = fe_rdata;
        state_d         = S_EDGE;
      end

      S_EDGE: begin
        if (e_q >= edge_cnt_q) begin
          state_d = S_POP;
        end else begin
          ed_raddr = e_q[EW-1:0];
          fl_raddr = e_q[EW-1:0];
          state_d  = S_EV;
        end
      end

      S_EV: begin
        v_d      = ed_rdata.target;
        link_d   = ed_rdata.link;
        nd_d     = du_q + 32'(ed_rdata.weight);
        ok_d     = resid > 32'sd0;
        nd_raddr = ed_rdata.target;
        state_d  = S_RELAX;
      end

      S_RELAX: begin
        e_d     = link_q;
        state_d = S_EDGE;
        if (ok_q && nd_rdata.path_cost > nd_q) begin
          if (!nd_rdata.queued && nd_rdata.tally == TW'(MAX_NODES)) begin
            state_d = S_RESP;
          end else begin
            nd_we              = 1'b1;
            nd_waddr           = v_q;
            nd_wdata           = nd_rdata;
            nd_wdata.path_cost = nd_q;
            nd_wdata.pred      = e_q;
            if (v_q == u_q) begin
              du_d = nd_q;
            end
            if (!nd_rdata.queued) begin
              nd_wdata.queued = 1'b1;
              nd_wdata.tally  = nd_rdata.tally + 1'b1;
              wq_we  = 1'b1;
              wr_d   = (wr_q == NW'(MAX_NODES - 1)) ? '0 : wr_q + 1'b1;
              fill_d = fill_q + 1'b1;
            end
          end
        end
      end

      S_CHKW: begin
        if (nd_rdata.pred == NO_EDGE) begin
          state_d = S_RESP;
        end else begin
          dsink_d = nd_rdata.path_cost;
          psink_d = nd_rdata.pred;
          e_d     = nd_rdata.pred;
          low_d   = 30'(FLOW_INF);
          steps_d = '0;
          aug_d   = 1'b0;
          state_d = S_WA;
        end
      end

      S_WA: begin
        if (e_q == NO_EDGE) begin
          if (aug_q) begin
            state_d = S_MUL;
          end else begin
            aug_d = 1'b1;
            e_d   = psink_q;
          end
        end else if (!aug_q && steps_q == TW'(MAX_NODES)) begin
          state_d = S_RESP;
        end else begin
          steps_d  = steps_q + 1'b1;
          ed_raddr = e_q[EW-1:0];
          fl_raddr = e_q[EW-1:0];
          state_d  = S_WB;
        end
      end

      S_WB: begin
        if (aug_q) begin
          fl_we    = 1'b1;
          fl_waddr = e_q[EW-1:0];
          fl_wdata = fl_rdata + {1'b0, low_q};
        end else if (resid < $signed({2'b00, low_q})) begin
          low_d = resid[29:0];
        end
        ed_raddr = e_pair;
        fl_raddr = e_pair;
        state_d  = S_WC;
      end

      S_WC: begin
        if (aug_q) begin
          fl_we    = 1'b1;
          fl_waddr = e_pair;
          fl_wdata = fl_rdata - {1'b0, low_q};
        end
        nd_raddr = ed_rdata.target;
        state_d  = S_WD;
      end

      S_WD: begin
        e_d     = nd_rdata.pred;
        state_d = S_WA;
      end

      S_MUL: begin
        prod_d  = $signed({2'b00, low_q}) * dsink_q;
        state_d = S_ACC;
      end

      S_ACC: begin
        if (cost_sum < 64'sd0) begin
          cost_d = '0;
        end else if (cost_sum > $signed({16'd0, COST_MAX})) begin
          cost_d = COST_MAX;
        end else begin
          cost_d = cost_sum[47:0];
        end
        flow_d = flow_sum[32] ? '1 : flow_sum[31:0];
        cnt_d  = '0;
        if (es_en_q && prod_q > 64'sd0 && prod_q > $signed({32'd0, limit_q})) begin
          state_d = S_RESP;
        end else begin
          state_d = S_INIT;
        end
      end

      S_RESP: begin
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      cnt_q      <= '0;
      rpt_q      <= 1'b0;
      edge_cnt_q <= '0;
      src_q      <= 10'd0;
      snk_q      <= 10'd1023;
      es_en_q    <= 1'b0;
      limit_q    <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      fill_q     <= '0;
      steps_q    <= '0;
      aug_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rpt_q      <= rpt_d;
      edge_cnt_q <= edge_cnt_d;
      src_q      <= src_d;
      snk_q      <= snk_d;
      es_en_q    <= es_en_d;
      limit_q    <= limit_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      fill_q     <= fill_d;
      steps_q    <= steps_d;
      aug_q      <= aug_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    cap_q    <= cap_d;
    w_q      <= w_d;
    u_q      <= u_d;
    du_q     <= du_d;
    e_q      <= e_d;
    v_q      <= v_d;
    link_q   <= link_d;
    nd_q     <= nd_d;
    ok_q     <= ok_d;
    dsink_q  <= dsink_d;
    psink_q  <= psink_d;
    low_q    <= low_d;
    prod_q   <= prod_d;
    status_q <= status_d;
    flow_q   <= flow_d;
    cost_q   <= cost_d;
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block not busy after a command transfer");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= TW'(MAX_NODES))
    else $error("work queue fill exceeds its depth");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_FULL || status_o == ST_RANGE))
    else $error("undefined status code reported");

  a_edge_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !edge_cnt_q[0] && 32'(edge_cnt_q) <= MAX_EDGES)
    else $error("edge count odd or beyond the edge store");

endmodule

// File: design/mcmf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mcmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sim/tb_min_cost_max_flow_engine_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for min_cost_max_flow_engine_unit: a directed table,
// then random graph commands, checked against a behavioral flow predictor.
// Depends on mcmf_pkg and the design files under design/.
module tb_min_cost_max_flow_engine_unit
  import mcmf_pkg::*;
;

  localparam int NODES = 1024;
  localparam int EDGES = 16384;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned NO_EDGE = 32'hffff_ffff;
  localparam int unsigned CAP_INF = 32'h3f3f_3f3f;
  localparam int STALL_LIMIT = 2000000;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  op;
    logic [9:0]  src;
    logic [9:0]  dst;
    logic [31:0] val;
    logic [15:0] cost;
    bit          typed;
    logic [1:0]  st;
    logic [31:0] fl;
    logic [47:0] co;
  } plan_row_t;

  typedef struct {
    logic [1:0]  st;
    logic [31:0] fl;
    logic [47:0] co;
  } flow_answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = '0;
  logic [9:0]  from_node_i = '0;
  logic [9:0]  to_node_i = '0;
  logic [29:0] capacity_i = '0;
  logic [15:0] unit_cost_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] total_flow_o;
  logic [47:0] total_cost_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  min_cost_max_flow_engine_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted graph state and registers.
  int unsigned e_to [EDGES];
  int unsigned e_next [EDGES];
  longint      e_cap [EDGES];
  longint      e_flow [EDGES];
  longint      e_wt [EDGES];
  int unsigned head_edge [NODES];
  int unsigned n_edges;
  longint      path_cost [NODES];
  int unsigned pred [NODES];
  bit          queued [NODES];
  int unsigned fifo [NODES];
  int unsigned pushes [NODES];
  int unsigned reg_src, reg_dst;
  bit          reg_es;
  longint      reg_limit;

  flow_answer_t pending_answers[$];
  plan_row_t    plan[$];
  int           gap_pct = 0;
  bit           failed = 1'b0;
  int           quiet_cycles = 0;

  function automatic void link_edge(int unsigned a, int unsigned b, longint c, longint w);
    e_to[n_edges] = b;
    e_cap[n_edges] = c;
    e_wt[n_edges] = w;
    e_flow[n_edges] = 0;
    e_next[n_edges] = head_edge[a];
    head_edge[a] = n_edges;
    n_edges++;
  endfunction

  function automatic bit find_cheapest_path();
    int unsigned rd, wr, fill, u, v, e;
    longint nd;
    rd = 0; wr = 0;
    for (int n = 0; n < NODES; n++) begin
      path_cost[n] = CAP_INF;
      queued[n] = 1'b0;
      pred[n] = NO_EDGE;
      pushes[n] = 0;
    end
    path_cost[reg_src] = 0;
    queued[reg_src] = 1'b1;
    pushes[reg_src] = 1;
    fifo[wr] = reg_src;
    wr = (wr + 1) % NODES;
    fill = 1;
    while (fill > 0) begin
      u = fifo[rd];
      rd = (rd + 1) % NODES;
      fill--;
      queued[u] = 1'b0;
      for (e = head_edge[u]; e < n_edges; e = e_next[e]) begin
        v = e_to[e];
        nd = path_cost[u] + e_wt[e];
        if (e_cap[e] > e_flow[e] && path_cost[v] > nd) begin
          path_cost[v] = nd;
          pred[v] = e;
          if (!queued[v]) begin
            pushes[v]++;
            if (pushes[v] > NODES) return 1'b0;
            queued[v] = 1'b1;
            fifo[wr] = v;
            wr = (wr + 1) % NODES;
            fill++;
          end
        end
      end
    end
    return pred[reg_dst] != NO_EDGE;
  endfunction

  function automatic flow_answer_t predict_flow(logic [1:0] op, int unsigned a,
                                                int unsigned b, longint c, longint w);
    flow_answer_t r;
    longint unsigned flow;
    longint cost, low, aug;
    int unsigned e, steps;
    bit broken;
    r = '{ST_OK, '0, '0};
    flow = 0;
    cost = 0;
    case (op)
      OP_CLEAR: begin
        for (int n = 0; n < NODES; n++) head_edge[n] = NO_EDGE;
        n_edges = 0;
      end
      OP_ADD: begin
        if (a >= NODES || b >= NODES) r.st = ST_RANGE;
        else if (n_edges + 2 > EDGES) r.st = ST_FULL;
        else begin
          link_edge(a, b, c, w);
          link_edge(b, a, 0, -w);
        end
      end
      OP_RUN: begin
        if (reg_src >= NODES || reg_dst >= NODES) r.st = ST_RANGE;
        else begin
          for (int i = 0; i < n_edges; i++) e_flow[i] = 0;
          while (find_cheapest_path()) begin
            low = CAP_INF;
            broken = 1'b0;
            steps = 0;
            for (e = pred[reg_dst]; e != NO_EDGE; e = pred[e_to[e ^ 1]]) begin
              steps++;
              if (steps > NODES) begin
                broken = 1'b1;
                break;
              end
              if (low > e_cap[e] - e_flow[e]) low = e_cap[e] - e_flow[e];
            end
            if (broken) break;
            for (e = pred[reg_dst]; e != NO_EDGE; e = pred[e_to[e ^ 1]]) begin
              e_flow[e] += low;
              e_flow[e ^ 1] -= low;
            end
            aug = low * path_cost[reg_dst];
            cost += aug;
            if (cost < 0) cost = 0;
            if (cost > longint'(COST_MAX)) cost = longint'(COST_MAX);
            flow += low;
            if (flow > 64'hffff_ffff) flow = 64'hffff_ffff;
            if (reg_es && aug > 0 && aug > reg_limit) break;
          end
          r.fl = flow[31:0];
          r.co = cost[47:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_cmd(plan_row_t row);
    flow_answer_t p;
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start = 1'b1;
    opcode_i = row.op;
    from_node_i = row.src;
    to_node_i = row.dst;
    capacity_i = row.val[29:0];
    unit_cost_i = row.cost;
    do @(posedge clk_i); while (busy);
    p = predict_flow(row.op, row.src, row.dst, row.val[29:0], row.cost);
    if (row.typed) p = '{row.st, row.fl, row.co};
    pending_answers.insert(pending_answers.size(), p);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_answers.size() > 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    drain();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SOURCE: reg_src = data[9:0];
      CFG_SINK:   reg_dst = data[9:0];
      CFG_ES_EN:  reg_es = data[0];
      default:    reg_limit = data;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic plan_row_t cmd(logic [1:0] op, int unsigned a, int unsigned b,
                                    int unsigned c, int unsigned w);
    return '{1'b0, op, 10'(a), 10'(b), c, 16'(w), 1'b0, ST_OK, '0, '0};
  endfunction

  function automatic plan_row_t known(plan_row_t r, logic [31:0] fl, logic [47:0] co);
    r.typed = 1'b1;
    r.fl = fl;
    r.co = co;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [1:0] idx, logic [31:0] data);
    plan_row_t r;
    r = cmd(OP_CLEAR, 0, 0, 0, 0);
    r.is_cfg = 1'b1;
    r.op = idx;
    r.val = data;
    return r;
  endfunction

  function automatic void add_row(plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic int unsigned pick_node();
    if ($urandom_range(99) < 8) return $urandom_range(NODES - 1);
    return $urandom_range(5);
  endfunction

  function automatic plan_row_t random_cmd();
    int unsigned roll, c;
    roll = $urandom_range(99);
    if (n_edges > 60 || roll < 3) return cmd(OP_CLEAR, pick_node(), pick_node(), 0, 0);
    if (roll < 5) return cmd(OP_UNUSED, pick_node(), pick_node(), $urandom, $urandom);
    if (roll < 11) return cmd(OP_RUN, pick_node(), pick_node(), 0, 0);
    case ($urandom_range(9))
      0: c = CAP_INF;
      1: c = $urandom_range(CAP_INF);
      2: c = 0;
      default: c = $urandom_range(1, 20);
    endcase
    return cmd(OP_ADD, pick_node(), pick_node(), c,
               ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(12));
  endfunction

  always @(posedge clk_i) begin
    flow_answer_t x;
    if (rst_ni) begin
      if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("min_cost_max_flow_engine_unit regression: fail");
        $finish;
      end
      if (done_o) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result st=%0d flow=%0d cost=%0d", $realtime,
                   status_o, total_flow_o, total_cost_o);
          failed = 1'b1;
        end else begin
          x = pending_answers.pop_front();
          if (status_o !== x.st) begin
            $display("%0t: status expected %0d actual %0d", $realtime, x.st, status_o);
            failed = 1'b1;
          end
          if (total_flow_o !== x.fl) begin
            $display("%0t: total_flow expected %0d actual %0d", $realtime, x.fl,
                     total_flow_o);
            failed = 1'b1;
          end
          if (total_cost_o !== x.co) begin
            $display("%0t: total_cost expected %0d actual %0d", $realtime, x.co,
                     total_cost_o);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin
    for (int n = 0; n < NODES; n++) head_edge[n] = NO_EDGE;
    n_edges = 0;
    reg_src = 0;
    reg_dst = 1023;
    reg_es = 1'b0;
    reg_limit = 0;

    add_row(known(cmd(OP_RUN, 0, 0, 0, 0), '0, '0));
    add_row(known(cmd(OP_UNUSED, 1023, 1023, 30'h3fff_ffff, 16'hffff), '0, '0));
    add_row(known(cmd(OP_CLEAR, 0, 0, 0, 0), '0, '0));
    add_row(reg_row(CFG_SINK, 1));
    repeat (5) add_row(known(cmd(OP_ADD, 0, 1, CAP_INF, 65535), '0, '0));
    add_row(known(cmd(OP_RUN, 0, 0, 0, 0), 32'hffff_ffff, COST_MAX));
    add_row(known(cmd(OP_CLEAR, 0, 0, 0, 0), '0, '0));
    add_row(cmd(OP_ADD, 0, 2, 5, 3));
    add_row(cmd(OP_ADD, 2, 1, 3, 4));
    add_row(cmd(OP_ADD, 0, 1, 10, 10));
    add_row(cmd(OP_ADD, 1, 1023, 0, 0));
    add_row(cmd(OP_ADD, 1023, 0, 1, 0));
    add_row(cmd(OP_ADD, 2, 2, 7, 1));
    add_row(cmd(OP_RUN, 0, 0, 0, 0));
    add_row(reg_row(CFG_ES_EN, 1));
    add_row(reg_row(CFG_LIMIT, 20));
    add_row(cmd(OP_RUN, 0, 0, 0, 0));
    add_row(reg_row(CFG_LIMIT, 32'hffff_ffff));
    add_row(cmd(OP_RUN, 0, 0, 0, 0));
    add_row(reg_row(CFG_SOURCE, 1));
    add_row(known(cmd(OP_RUN, 0, 0, 0, 0), '0, '0));
    add_row(reg_row(CFG_SOURCE, 1023));
    add_row(cmd(OP_RUN, 0, 0, 0, 0));
    add_row(reg_row(CFG_SOURCE, 0));
    add_row(reg_row(CFG_ES_EN, 0));
    add_row(reg_row(CFG_LIMIT, 0));
    add_row(known(cmd(OP_CLEAR, 0, 0, 0, 0), '0, '0));

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].op, plan[i].val);
      else send_cmd(plan[i]);
    end

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 29 : (ph == 1) ? 47 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        write_reg(CFG_SOURCE, ($urandom_range(9) == 0) ? $urandom : $urandom_range(5));
        write_reg(CFG_SINK, ($urandom_range(9) == 0) ? $urandom : $urandom_range(5));
        write_reg(CFG_ES_EN, $urandom);
        case ($urandom_range(3))
          0: write_reg(CFG_LIMIT, 0);
          1: write_reg(CFG_LIMIT, 32'hffff_ffff);
          2: write_reg(CFG_LIMIT, $urandom);
          default: write_reg(CFG_LIMIT, $urandom_range(200));
        endcase
        repeat (64) send_cmd(random_cmd());
      end
    end

    drain();
    if (!failed) begin
      $display("min_cost_max_flow_engine_unit regression: pass");
    end else begin
      $display("min_cost_max_flow_engine_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/mcmf_pkg.sv
design/mcmf_ram.sv
design/min_cost_max_flow_engine_unit.sv
sim/tb_min_cost_max_flow_engine_unit.sv
